[rtl/appm_pkg.sv]
`timescale 1ns / 1ps

package appm_pkg;

   // Sample and magnitude widths
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 16;

   // PCM scaling: times 32767, then shift right by 15
   localparam int PCM_SCALE  = 32767;
   localparam int PCM_SHIFT  = 15;

   // Control register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_DATA_W-1:0] WINDOW_RESET = 14'd4800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERT_POLARITY = 1'b0,
      CSR_WINDOW_LENGTH   = 1'b1
   } csr_index_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic accept;
      logic pop_head;
      logic pop_tail;
      logic push;
   } appm_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic empty;
      logic head_expired;
      logic tail_dominated;
      logic out_free;
   } appm_sts_type;

endpackage

[rtl/audio_playback_peak_meter.sv]
`timescale 1ns / 1ps

// Audio peak meter with PCM conversion.
// Input channel (req_*): one Q1.15 sample per word plus a first-of-run flag
// that empties the peak window before that sample, as at playback start.
// Result channel (rsp_*): one word per input word, in order: the sample
// (negated when invert polarity is set) scaled by 32767/32768 and truncated
// toward zero, and the largest magnitude among the last window_length samples.
// Control registers (csr_*): index 0 invert polarity, index 1 window length
// (0 acts as 1, values above WINDOW_MAX saturate). Write them only while idle.
// Sequence: each word passes through accept, candidate store read and
// decide/push before the next word is accepted, and its result is registered
// at the push; every candidate dropped from the head (aged out) or the tail
// (dominated by the new magnitude) adds another candidate store read and
// decide step. Each candidate is dropped at most once.
// The result sits in an output register, so the next word is accepted while
// it waits; if the receiver stalls, the following word waits before its push.
// Reset: empties the window, clears the sample stamp, invert polarity 0,
// window length 4800. The candidate store needs no clearing pass.
module audio_playback_peak_meter
   import appm_pkg::*;
#(
   parameter int WINDOW_MAX = 8192
)
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_first_of_run,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_pcm_out,
   output logic [MAG_W-1:0]           rsp_window_peak,

   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int WW = $clog2(WINDOW_MAX + 1);

   logic                  invert_ff;
   logic [CSR_DATA_W-1:0] wlen_ff;
   logic [WW-1:0]         win;
   appm_cmd_type          cmd;
   appm_sts_type          sts;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
         wlen_ff   <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_INVERT_POLARITY: invert_ff <= csr_write_data[0];
            CSR_WINDOW_LENGTH:   wlen_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Effective window: zero acts as one, saturate at capacity
   always_comb begin
      priority if (wlen_ff == '0) begin
         win = WW'(1);
      end else if (32'(wlen_ff) > 32'(WINDOW_MAX)) begin
         win = WW'(WINDOW_MAX);
      end else begin
         win = WW'(wlen_ff);
      end
   end

   appm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   appm_datapath #(
      .WINDOW_MAX (WINDOW_MAX),
      .WW         (WW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_sample_in    (req_sample_in),
      .req_first_of_run (req_first_of_run),
      .invert           (invert_ff),
      .win              (win),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pcm_out      (rsp_pcm_out),
      .rsp_window_peak  (rsp_window_peak)
   );

endmodule

[rtl/appm_ctrl.sv]
`timescale 1ns / 1ps

module appm_ctrl
   import appm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  appm_sts_type sts,
   output appm_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // Decode commands: accept when idle; in check, expire the head first, then trim the tail, then push.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_FETCH: begin
         end
         ST_CHECK: begin
            priority if (!sts.empty && sts.head_expired) begin
               cmd.pop_head = 1'b1;
            end else if (!sts.empty && sts.tail_dominated) begin
               cmd.pop_tail = 1'b1;
            end else if (sts.out_free) begin
               cmd.push = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cmd.pop_head || cmd.pop_tail) state_in = ST_FETCH;
            else if (cmd.push)                state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

[rtl/appm_datapath.sv]
`timescale 1ns / 1ps

module appm_datapath
   import appm_pkg::*;
#(
   parameter int WINDOW_MAX = 8192,
   parameter int WW         = $clog2(WINDOW_MAX + 1)
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_first_of_run,
   input  logic                       invert,
   input  logic [WW-1:0]              win,
   input  appm_cmd_type               cmd,
   output appm_sts_type               sts,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_pcm_out,
   output logic [MAG_W-1:0]           rsp_window_peak
);

   localparam int PW   = $clog2(WINDOW_MAX);
   localparam int SW   = $clog2(WINDOW_MAX) + 1;
   localparam int CNTW = $clog2(WINDOW_MAX + 1);
   localparam int PRW  = MAG_W + PCM_SHIFT;

   typedef struct packed {
      logic [MAG_W-1:0] value;
      logic [SW-1:0]    stamp;
   } entry_type;

   entry_type        cand_mem_ff [WINDOW_MAX];
   entry_type        rd_head_ff;
   entry_type        rd_tail_ff;

   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic [SW-1:0]    stamp_ff;
   logic [MAG_W-1:0] mag_ff;
   logic             neg_ff;

   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_pcm_ff;
   logic [MAG_W-1:0]           out_peak_ff;

   logic [PW-1:0]    tail_prev;
   logic [MAG_W-1:0] mag_in;
   logic             full;
   logic             wr_en;
   logic [SW-1:0]    age;
   logic [PRW-1:0]   prod;
   logic [MAG_W-1:0] pcm_mag;
   logic [MAG_W-1:0] peak;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
   endfunction

   assign tail_prev = (tail_ff == '0) ? PW'(WINDOW_MAX - 1) : tail_ff - 1'b1;
   assign mag_in    = req_sample_in[SAMPLE_W-1] ? (~req_sample_in + 1'b1) : req_sample_in;
   assign full      = (count_ff == CNTW'(WINDOW_MAX));
   assign wr_en     = cmd.push && !full;
   assign age       = stamp_ff - rd_head_ff.stamp;

   assign sts.empty          = (count_ff == '0);
   assign sts.head_expired   = (age >= SW'(win));
   assign sts.tail_dominated = (rd_tail_ff.value <= mag_ff);
   assign sts.out_free       = !out_valid_ff || rsp_ready;

   // Queue pointers and occupancy
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      priority if (cmd.accept && req_first_of_run) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd.pop_head) begin
         head_in  = ptr_inc(head_ff);
         count_in = count_ff - 1'b1;
      end else if (cmd.pop_tail) begin
         tail_in  = tail_prev;
         count_in = count_ff - 1'b1;
      end else if (wr_en) begin
         tail_in  = ptr_inc(tail_ff);
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         stamp_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.push) stamp_ff <= stamp_ff + 1'b1;
      end
   end

   // Candidate store: one write port, head and tail-end read ports
   always_ff @(posedge clock) begin
      if (wr_en) cand_mem_ff[tail_ff] <= '{value: mag_ff, stamp: stamp_ff};
      rd_head_ff <= cand_mem_ff[head_ff];
      rd_tail_ff <= cand_mem_ff[tail_prev];
   end

   // Latch the accepted word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mag_ff <= mag_in;
         neg_ff <= req_sample_in[SAMPLE_W-1] ^ invert;
      end
   end

   // PCM: magnitude times 32767, shift by 15, restore sign
   assign prod    = PRW'(mag_ff) * PRW'(PCM_SCALE);
   assign pcm_mag = prod[PRW-1:PCM_SHIFT];
   assign peak    = sts.empty ? mag_ff : rd_head_ff.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_pcm_ff  <= neg_ff ? $signed(~pcm_mag + 1'b1) : $signed(pcm_mag);
         out_peak_ff <= peak;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pcm_out     = out_pcm_ff;
   assign rsp_window_peak = out_peak_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(WINDOW_MAX))
      else $error("candidate count above capacity");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.push && !(cmd.accept && req_first_of_run) |=> count_ff != '0)
      else $error("queue empty after push");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_head || cmd.pop_tail) |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule
